### design/ppmra_pkg.sv
package ppmra_pkg;

  localparam int unsigned WIDTH_W  = 16;
  localparam int unsigned SUM_W    = 20;
  localparam int unsigned STORED_W = 4;
  localparam int unsigned CENTER_W = 16;
  localparam int unsigned SEL_W    = 3;

  localparam logic [WIDTH_W-1:0] SYNC_GAP_RST = 16'd5000;

  // Item commands
  typedef enum logic [1:0] {
    CMD_EDGE = 2'd0,
    CMD_TICK = 2'd1,
    CMD_ARM  = 2'd2,
    CMD_CAL  = 2'd3
  } cmd_e;

  // Arming sequencer state codes
  localparam logic [1:0] PH_IDLE    = 2'd0;
  localparam logic [1:0] PH_POLL    = 2'd1;
  localparam logic [1:0] PH_RECHECK = 2'd2;
  localparam logic [1:0] PH_RELEASE = 2'd3;

  localparam int unsigned ARM_TICK_W = 5;
  localparam logic [ARM_TICK_W-1:0] RECHECK_TICKS = 5'd10;
  localparam logic [ARM_TICK_W-1:0] RELEASE_TICKS = 5'd30;

  // Stick thresholds in microseconds
  localparam logic [WIDTH_W-1:0] CH3_HI_THR  = 16'd1900;
  localparam logic [WIDTH_W-1:0] CH2_LO_THR  = 16'd1050;
  localparam logic [WIDTH_W-1:0] CH4_HI_THR  = 16'd1800;
  localparam logic [WIDTH_W-1:0] CH5_LO_THR  = 16'd1200;
  localparam logic [WIDTH_W-1:0] CH3_REL_THR = 16'd1600;

  // What a beat does to the center registers when it leaves the first stage
  typedef enum logic [1:0] {
    CEN_KEEP  = 2'd0,
    CEN_CLEAR = 2'd1,
    CEN_LOAD  = 2'd2
  } cen_op_e;

  typedef struct packed {
    logic [STORED_W-1:0]       stored;
    logic                      sync;
    logic                      busy;
    logic                      arm_done;
    logic                      cal_done;
    cen_op_e                   cen_op;
    logic [2:0][SUM_W-1:0]     sums;
  } stage_t;

  typedef struct packed {
    logic [STORED_W-1:0] stored;
    logic                sync;
    logic [WIDTH_W-1:0]  width;
    logic                busy;
    logic                arm_done;
    logic                cal_done;
  } result_t;

endpackage

### design/ppmra_if.sv
interface ppmra_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [ppmra_pkg::WIDTH_W-1:0]    data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface ppmra_in_if;
  logic                             valid;
  logic                             ready;
  logic [1:0]                       command;
  logic [ppmra_pkg::WIDTH_W-1:0]    interval_us;
  logic [ppmra_pkg::SEL_W-1:0]      channel_select;

  modport source (output valid, output command, output interval_us, output channel_select,
                  input ready);
  modport sink (input valid, input command, input interval_us, input channel_select,
                output ready);
endinterface

interface ppmra_out_if;
  logic                             valid;
  logic                             ready;
  logic [ppmra_pkg::STORED_W-1:0]   stored_channel;
  logic                             sync_seen;
  logic [ppmra_pkg::WIDTH_W-1:0]    channel_width;
  logic                             arming_busy;
  logic                             arm_done;
  logic                             cal_done;
  logic [ppmra_pkg::CENTER_W-1:0]   center_roll;
  logic [ppmra_pkg::CENTER_W-1:0]   center_pitch;
  logic [ppmra_pkg::CENTER_W-1:0]   center_yaw;

  modport source (output valid, output stored_channel, output sync_seen, output channel_width,
                  output arming_busy, output arm_done, output cal_done, output center_roll,
                  output center_pitch, output center_yaw, input ready);
  modport sink (input valid, input stored_channel, input sync_seen, input channel_width,
                input arming_busy, input arm_done, input cal_done, input center_roll,
                input center_pitch, input center_yaw, output ready);
endinterface

### design/ppmra_chan_store.sv
module ppmra_chan_store #(
  parameter int unsigned DEPTH = 8,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              wr_en_i,
  input  logic [AW-1:0]                     wr_addr_i,
  input  logic [ppmra_pkg::WIDTH_W-1:0]     wr_data_i,
  input  logic                              rd_en_i,
  input  logic                              rd_ok_i,
  input  logic [AW-1:0]                     rd_addr_i,
  output logic [ppmra_pkg::WIDTH_W-1:0]     rd_data_o
);

  logic [ppmra_pkg::WIDTH_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]              vld_q;
  logic [ppmra_pkg::WIDTH_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // entries never written read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en_i) begin
      vld_q[wr_addr_i] <= 1'b1;
    end
  end

  // registered read, new data forwarded on a same-address write
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      if (!rd_ok_i) begin
        rd_data_q <= '0;
      end else if (wr_en_i && (wr_addr_i == rd_addr_i)) begin
        rd_data_q <= wr_data_i;
      end else if (!vld_q[rd_addr_i]) begin
        rd_data_q <= '0;
      end else begin
        rd_data_q <= mem_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

### design/ppm_receiver_with_arming_core.sv
// Beats are registered in stage 1, then in the result register. One input beat
// is taken per cycle while res_o is ready; the channel store gives one read and
// one write per cycle. While a result waits, stage 1 still takes one more input
// beat. Reset (rst_ni, async, active low) clears all control state; the channel
// store is cleared through per-entry valid bits, so no clearing pass is needed.
module ppm_receiver_with_arming_core #(
  parameter int unsigned NUM_CHANNELS = 8,
  parameter int unsigned CAL_SAMPLES  = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  ppmra_cfg_if.sink           cfg_i,
  ppmra_in_if.sink            in_i,
  ppmra_out_if.source         res_o
);

  localparam int unsigned CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
  localparam int unsigned POS_W = $clog2(NUM_CHANNELS + 1);
  localparam int unsigned SUM_W = ppmra_pkg::SUM_W;

  // floor(sum / CAL_SAMPLES) as a multiply by a rounded-up reciprocal; with
  // DIV_S = SUM_W + ceil(log2 CAL_SAMPLES) the quotient is exact for any sum.
  localparam int unsigned     DIV_L  = $clog2(CAL_SAMPLES);
  localparam int unsigned     DIV_S  = SUM_W + DIV_L;
  localparam int unsigned     M_W    = DIV_S + 1;
  localparam longint unsigned DIV_M  = ((longint'(1) << DIV_S) + CAL_SAMPLES - 1) / CAL_SAMPLES;
  localparam int unsigned     PROD_W = SUM_W + M_W;
  localparam int unsigned     QUO_W  = PROD_W - DIV_S;

  // ---------------------------------------------------------------------------
  // Configuration register: always ready; write only between items (unenforced).
  // ---------------------------------------------------------------------------
  logic [ppmra_pkg::WIDTH_W-1:0] sync_gap_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_gap_q <= ppmra_pkg::SYNC_GAP_RST;
    end else if (cfg_i.valid) begin
      sync_gap_q <= cfg_i.data;
    end
  end

  // ---------------------------------------------------------------------------
  // Beat flow: input -> stage 1 (store read data + control) -> result register.
  // ---------------------------------------------------------------------------
  logic                  s1_vld_q;
  ppmra_pkg::stage_t     s1_q;
  ppmra_pkg::stage_t     s1_d;
  logic                  out_vld_q;
  ppmra_pkg::result_t    out_q;
  logic                  s1_go;
  logic                  in_rdy;
  logic                  acc;
  ppmra_pkg::cmd_e       cmd;

  assign s1_go    = s1_vld_q && (!out_vld_q || res_o.ready);
  assign in_rdy   = !s1_vld_q || s1_go;
  assign in_i.ready = in_rdy;
  assign acc      = in_i.valid && in_rdy;
  assign cmd      = ppmra_pkg::cmd_e'(in_i.command);

  // ---------------------------------------------------------------------------
  // PPM framing: sync gap restarts the frame, other pulses fill slots until full.
  // ---------------------------------------------------------------------------
  logic [POS_W-1:0]              pos_q;
  logic [POS_W-1:0]              pos_d;
  logic                          is_edge;
  logic                          is_sync;
  logic                          wr_en;
  logic [ppmra_pkg::WIDTH_W-1:0] rd_data;
  logic                          rd_ok;

  assign is_edge = (cmd == ppmra_pkg::CMD_EDGE);
  assign is_sync = is_edge && (in_i.interval_us > sync_gap_q);
  assign wr_en   = acc && is_edge && !is_sync && (pos_q < POS_W'(NUM_CHANNELS));
  assign rd_ok   = (32'(in_i.channel_select) < NUM_CHANNELS);

  always_comb begin
    pos_d = pos_q;
    if (acc && is_sync) begin
      pos_d = '0;
    end else if (wr_en) begin
      pos_d = pos_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= POS_W'(NUM_CHANNELS);
    end else begin
      pos_q <= pos_d;
    end
  end

  ppmra_chan_store #(
    .DEPTH (NUM_CHANNELS)
  ) u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (pos_q[CH_W-1:0]),
    .wr_data_i (in_i.interval_us),
    .rd_en_i   (acc),
    .rd_ok_i   (rd_ok),
    .rd_addr_i (CH_W'(in_i.channel_select)),
    .rd_data_o (rd_data)
  );

  // ---------------------------------------------------------------------------
  // Tick-time views of the store. Stick tests and the calibration channels are
  // captured as the slot is written, so a tick needs no extra store reads.
  // Slots beyond the channel count never get written and keep the zero view.
  // ---------------------------------------------------------------------------
  logic                          ch3_hi_q;
  logic                          ch2_lo_q;
  logic                          ch4_hi_q;
  logic                          ch5_lo_q;
  logic                          ch3_rel_q;
  logic [ppmra_pkg::WIDTH_W-1:0] ch0_q;
  logic [ppmra_pkg::WIDTH_W-1:0] ch1_q;
  logic [ppmra_pkg::WIDTH_W-1:0] ch3_q;
  logic [4:0]                    wr_slot;

  assign wr_slot = 5'(pos_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch3_hi_q  <= 1'b0;
      ch2_lo_q  <= 1'b1;
      ch4_hi_q  <= 1'b0;
      ch5_lo_q  <= 1'b1;
      ch3_rel_q <= 1'b1;
      ch0_q     <= '0;
      ch1_q     <= '0;
      ch3_q     <= '0;
    end else if (wr_en) begin
      if (wr_slot == 5'd0) begin
        ch0_q <= in_i.interval_us;
      end
      if (wr_slot == 5'd1) begin
        ch1_q <= in_i.interval_us;
      end
      if (wr_slot == 5'd2) begin
        ch2_lo_q <= (in_i.interval_us < ppmra_pkg::CH2_LO_THR);
      end
      if (wr_slot == 5'd3) begin
        ch3_q     <= in_i.interval_us;
        ch3_hi_q  <= (in_i.interval_us > ppmra_pkg::CH3_HI_THR);
        ch3_rel_q <= (in_i.interval_us < ppmra_pkg::CH3_REL_THR);
      end
      if (wr_slot == 5'd4) begin
        ch4_hi_q <= (in_i.interval_us > ppmra_pkg::CH4_HI_THR);
      end
      if (wr_slot == 5'd5) begin
        ch5_lo_q <= (in_i.interval_us < ppmra_pkg::CH5_LO_THR);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Arming sequencer: poll pattern, recheck after 10 ticks, throttle test
  // after 30 more. A failed test drops back to polling.
  // ---------------------------------------------------------------------------
  logic [1:0]                          phase_q;
  logic [1:0]                          phase_d;
  logic [ppmra_pkg::ARM_TICK_W-1:0]    ticks_q;
  logic [ppmra_pkg::ARM_TICK_W-1:0]    ticks_d;
  logic [ppmra_pkg::ARM_TICK_W-1:0]    ticks_dec;
  logic                                pattern;
  logic                                arm_done;

  assign pattern   = ch3_hi_q && ch2_lo_q && ch4_hi_q && ch5_lo_q;
  assign ticks_dec = (ticks_q != '0) ? ticks_q - ppmra_pkg::ARM_TICK_W'(1) : ticks_q;

  always_comb begin
    phase_d  = phase_q;
    ticks_d  = ticks_q;
    arm_done = 1'b0;
    unique case (cmd)
      ppmra_pkg::CMD_TICK: begin
        if (phase_q == ppmra_pkg::PH_POLL) begin
          if (pattern) begin
            phase_d = ppmra_pkg::PH_RECHECK;
            ticks_d = ppmra_pkg::RECHECK_TICKS;
          end
        end else if (phase_q == ppmra_pkg::PH_RECHECK ||
                     phase_q == ppmra_pkg::PH_RELEASE) begin
          ticks_d = ticks_dec;
          if (ticks_dec == '0) begin
            if (phase_q == ppmra_pkg::PH_RECHECK) begin
              if (pattern) begin
                phase_d = ppmra_pkg::PH_RELEASE;
                ticks_d = ppmra_pkg::RELEASE_TICKS;
              end else begin
                phase_d = ppmra_pkg::PH_POLL;
              end
            end else if (ch3_rel_q) begin
              phase_d  = ppmra_pkg::PH_IDLE;
              arm_done = 1'b1;
            end else begin
              phase_d = ppmra_pkg::PH_POLL;
            end
          end
        end
      end
      ppmra_pkg::CMD_ARM: begin
        phase_d = ppmra_pkg::PH_POLL;
        ticks_d = '0;
      end
      ppmra_pkg::CMD_EDGE,
      ppmra_pkg::CMD_CAL: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ppmra_pkg::PH_IDLE;
      ticks_q <= '0;
    end else if (acc) begin
      phase_q <= phase_d;
      ticks_q <= ticks_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Calibration: accumulate ch0, ch1, ch3 over CAL_SAMPLES ticks. The final
  // sums ride with the beat; the divide runs as it leaves stage 1.
  // ---------------------------------------------------------------------------
  logic [2:0][SUM_W-1:0] sums_q;
  logic [2:0][SUM_W-1:0] sums_d;
  logic [2:0][SUM_W-1:0] sums_add;
  logic [3:0]            cnt_q;
  logic [3:0]            cnt_d;
  logic                  cal_act_q;
  logic                  cal_act_d;
  logic                  cal_fin;
  ppmra_pkg::cen_op_e    cen_op;

  assign sums_add[0] = sums_q[0] + SUM_W'(ch0_q);
  assign sums_add[1] = sums_q[1] + SUM_W'(ch1_q);
  assign sums_add[2] = sums_q[2] + SUM_W'(ch3_q);

  always_comb begin
    sums_d    = sums_q;
    cnt_d     = cnt_q;
    cal_act_d = cal_act_q;
    cal_fin   = 1'b0;
    cen_op    = ppmra_pkg::CEN_KEEP;
    unique case (cmd)
      ppmra_pkg::CMD_TICK: begin
        if (cal_act_q) begin
          sums_d = sums_add;
          cnt_d  = cnt_q + 4'd1;
          if ((cnt_q + 4'd1) >= 4'(CAL_SAMPLES)) begin
            cal_act_d = 1'b0;
            cal_fin   = 1'b1;
            cen_op    = ppmra_pkg::CEN_LOAD;
          end
        end
      end
      ppmra_pkg::CMD_CAL: begin
        sums_d    = '0;
        cnt_d     = '0;
        cal_act_d = 1'b1;
        cen_op    = ppmra_pkg::CEN_CLEAR;
      end
      ppmra_pkg::CMD_EDGE,
      ppmra_pkg::CMD_ARM: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sums_q    <= '0;
      cnt_q     <= '0;
      cal_act_q <= 1'b0;
    end else if (acc) begin
      sums_q    <= sums_d;
      cnt_q     <= cnt_d;
      cal_act_q <= cal_act_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1 register
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_d.stored   = wr_en ? ppmra_pkg::STORED_W'(pos_q)
                          : ppmra_pkg::STORED_W'(NUM_CHANNELS);
    s1_d.sync     = is_sync;
    s1_d.busy     = (phase_d != ppmra_pkg::PH_IDLE);
    s1_d.arm_done = arm_done;
    s1_d.cal_done = cal_fin;
    s1_d.cen_op   = cen_op;
    s1_d.sums     = sums_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (acc) begin
      s1_vld_q <= 1'b1;
    end else if (s1_go) begin
      s1_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      s1_q <= s1_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Centers: reciprocal multiply, saturated to 16 bits, applied in beat order
  // as stage 1 drains into the result register.
  // ---------------------------------------------------------------------------
  logic [2:0][PROD_W-1:0]              prod;
  logic [2:0][QUO_W-1:0]               quo;
  logic [2:0][ppmra_pkg::CENTER_W-1:0] cen_div;
  logic [2:0][ppmra_pkg::CENTER_W-1:0] cen_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      prod[i]    = PROD_W'(s1_q.sums[i]) * PROD_W'(M_W'(DIV_M));
      quo[i]     = prod[i][PROD_W-1:DIV_S];
      cen_div[i] = (|quo[i][QUO_W-1:ppmra_pkg::CENTER_W]) ? '1
                                                          : quo[i][ppmra_pkg::CENTER_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cen_q <= '0;
    end else if (s1_go) begin
      case (s1_q.cen_op)
        ppmra_pkg::CEN_CLEAR: cen_q <= '0;
        ppmra_pkg::CEN_LOAD:  cen_q <= cen_div;
        default:              cen_q <= cen_q;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (s1_go) begin
      out_vld_q <= 1'b1;
    end else if (res_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      out_q.stored   <= s1_q.stored;
      out_q.sync     <= s1_q.sync;
      out_q.width    <= rd_data;
      out_q.busy     <= s1_q.busy;
      out_q.arm_done <= s1_q.arm_done;
      out_q.cal_done <= s1_q.cal_done;
    end
  end

  assign res_o.valid          = out_vld_q;
  assign res_o.stored_channel = out_q.stored;
  assign res_o.sync_seen      = out_q.sync;
  assign res_o.channel_width  = out_q.width;
  assign res_o.arming_busy    = out_q.busy;
  assign res_o.arm_done       = out_q.arm_done;
  assign res_o.cal_done       = out_q.cal_done;
  assign res_o.center_roll    = cen_q[0];
  assign res_o.center_pitch   = cen_q[1];
  assign res_o.center_yaw     = cen_q[2];

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_ticks_only_waiting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ticks_q != '0) |-> (phase_q == ppmra_pkg::PH_RECHECK || phase_q == ppmra_pkg::PH_RELEASE))
    else $error("arming tick count set outside a wait phase");

  a_cal_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cal_act_q |-> (cnt_q < 4'(CAL_SAMPLES)))
    else $error("calibration still active past its sample count");

  a_arm_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_q.arm_done) |-> !s1_q.busy)
    else $error("arming reported done while still busy");

  a_sync_no_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q && s1_q.sync) |-> (s1_q.stored == ppmra_pkg::STORED_W'(NUM_CHANNELS)))
    else $error("sync beat also stored a channel");

  a_centers_move_in_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_go |=> $stable(cen_q))
    else $error("centers changed without a beat leaving stage 1");

endmodule

### bench/tb_ppm_receiver_with_arming_core.sv
module tb_ppm_receiver_with_arming_core;
  import ppmra_pkg::*;

  localparam int unsigned N_CH        = 8;
  localparam int unsigned CAL_N       = 10;
  localparam int unsigned CYCLE_LIMIT = 400000;

  // One result beat, all fields flattened for a single compare.
  typedef struct packed {
    logic [STORED_W-1:0] stored;
    logic                sync;
    logic [WIDTH_W-1:0]  width;
    logic                busy;
    logic                arm_done;
    logic                cal_done;
    logic [CENTER_W-1:0] roll;
    logic [CENTER_W-1:0] pitch;
    logic [CENTER_W-1:0] yaw;
  } ppm_beat_t;

  // Stick positions the frame generator aims for.
  typedef enum int {
    STICKS_ARM,
    STICKS_REL,
    STICKS_ANY
  } stick_mode_e;

  function automatic string beat_text(ppm_beat_t b);
    return $sformatf("slot=%0d sync=%0b width=%0d busy=%0b arm=%0b cal=%0b centers=%0d/%0d/%0d",
                     b.stored, b.sync, b.width, b.busy, b.arm_done, b.cal_done,
                     b.roll, b.pitch, b.yaw);
  endfunction

  // Decoder mirror plus the queue of result beats still owed by the block.
  class ppm_scoreboard;
    logic [WIDTH_W-1:0]    sync_gap;
    logic [WIDTH_W-1:0]    widths [N_CH];
    logic [3:0]            frame_pos;
    logic [1:0]            arm_phase;
    logic [ARM_TICK_W-1:0] arm_left;
    logic [SUM_W-1:0]      sums [3];
    logic [3:0]            cal_cnt;
    bit                    cal_on;
    logic [CENTER_W-1:0]   centers [3];
    ppm_beat_t             due_beats [$];
    int                    errors, checked, syncs, arms, cals;

    function new();
      sync_gap  = SYNC_GAP_RST;
      foreach (widths[i]) widths[i] = '0;
      frame_pos = N_CH;
      arm_phase = PH_IDLE;
      arm_left  = '0;
      foreach (sums[i]) sums[i] = '0;
      foreach (centers[i]) centers[i] = '0;
      cal_cnt   = '0;
      cal_on    = 1'b0;
      errors    = 0;
      checked   = 0;
      syncs     = 0;
      arms      = 0;
      cals      = 0;
    endfunction

    function void set_sync_gap(logic [WIDTH_W-1:0] v);
      sync_gap = v;
    endfunction

    function bit sticks_armed();
      return widths[3] > CH3_HI_THR && widths[2] < CH2_LO_THR &&
             widths[4] > CH4_HI_THR && widths[5] < CH5_LO_THR;
    endfunction

    function void predict_item(cmd_e cmd, logic [WIDTH_W-1:0] iv, logic [SEL_W-1:0] sel);
      ppm_beat_t        b;
      logic [SUM_W-1:0] q;
      b = '0;
      b.stored = N_CH;
      case (cmd)
        CMD_EDGE: begin
          if (iv > sync_gap) begin
            frame_pos = '0;
            b.sync = 1'b1;
          end else if (frame_pos < N_CH) begin
            widths[frame_pos] = iv;
            b.stored = frame_pos;
            frame_pos++;
          end
        end
        CMD_TICK: begin
          if (arm_phase == PH_POLL) begin
            if (sticks_armed()) begin
              arm_phase = PH_RECHECK;
              arm_left  = RECHECK_TICKS;
            end
          end else if (arm_phase != PH_IDLE) begin
            if (arm_left != 0) arm_left--;
            if (arm_left == 0) begin
              if (arm_phase == PH_RECHECK) begin
                if (sticks_armed()) begin
                  arm_phase = PH_RELEASE;
                  arm_left  = RELEASE_TICKS;
                end else begin
                  arm_phase = PH_POLL;
                end
              end else if (widths[3] < CH3_REL_THR) begin
                arm_phase  = PH_IDLE;
                b.arm_done = 1'b1;
              end else begin
                arm_phase = PH_POLL;
              end
            end
          end
          if (cal_on) begin
            sums[0] += widths[0];
            sums[1] += widths[1];
            sums[2] += widths[3];
            cal_cnt++;
            if (cal_cnt >= CAL_N) begin
              for (int i = 0; i < 3; i++) begin
                q = sums[i] / CAL_N;
                centers[i] = (q > 16'hFFFF) ? 16'hFFFF : q[CENTER_W-1:0];
              end
              cal_on     = 1'b0;
              b.cal_done = 1'b1;
            end
          end
        end
        CMD_ARM: begin
          arm_phase = PH_POLL;
          arm_left  = '0;
        end
        default: begin
          foreach (sums[i]) sums[i] = '0;
          foreach (centers[i]) centers[i] = '0;
          cal_cnt = '0;
          cal_on  = 1'b1;
        end
      endcase
      b.width = widths[sel];
      b.busy  = (arm_phase != PH_IDLE);
      b.roll  = centers[0];
      b.pitch = centers[1];
      b.yaw   = centers[2];
      due_beats.push_back(b);
    endfunction

    function void check_beat(ppm_beat_t got);
      ppm_beat_t want;
      checked++;
      syncs += got.sync;
      arms  += got.arm_done;
      cals  += got.cal_done;
      if (due_beats.size() == 0) begin
        errors++;
        if (errors <= 10) $display("result beat with none owed: %s", beat_text(got));
        return;
      end
      want = due_beats.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= 10)
          $display("result beat %0d wrong\n  expected %s\n  actual   %s",
                   checked, beat_text(want), beat_text(got));
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  ppmra_cfg_if cfg_bus ();
  ppmra_in_if  item_bus ();
  ppmra_out_if res_bus ();

  ppm_receiver_with_arming_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_bus),
    .in_i   (item_bus),
    .res_o  (res_bus)
  );

  ppm_scoreboard sb = new();

  // Stimulus knobs: percent chance of an idle burst per beat on each side.
  int in_gap_pct    = 0;
  int out_stall_pct = 0;
  int items_sent    = 0;
  int gap_settings  = 1;
  int cycle_count   = 0;
  // Arming generator: ticks since the last arm start, and the tick at
  // which the throttle stick is pulled back.
  int arm_age       = 0;
  int release_at    = 30;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats owed", cycle_count, sb.due_beats.size());
      $display("ppm_receiver_with_arming_core: mismatch");
      $finish;
    end
  end

  // Result monitor: sample at the rising edge, before the block updates.
  always @(posedge clk_i) begin : watch_results
    ppm_beat_t got;
    if (rst_ni && res_bus.valid && res_bus.ready) begin
      got.stored   = res_bus.stored_channel;
      got.sync     = res_bus.sync_seen;
      got.width    = res_bus.channel_width;
      got.busy     = res_bus.arming_busy;
      got.arm_done = res_bus.arm_done;
      got.cal_done = res_bus.cal_done;
      got.roll     = res_bus.center_roll;
      got.pitch    = res_bus.center_pitch;
      got.yaw      = res_bus.center_yaw;
      sb.check_beat(got);
    end
  end

  // Result-side backpressure: ready held and dropped for random stretches.
  initial begin : result_ready_gen
    int hold;
    hold = 0;
    res_bus.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (res_bus.ready && $urandom_range(0, 99) < out_stall_pct) begin
        res_bus.ready = 1'b0;
        hold = $urandom_range(0, 8);
      end else begin
        res_bus.ready = 1'b1;
        hold = $urandom_range(0, 12);
      end
    end
  end

  // All driver tasks start and end at a falling edge.
  task automatic send_item(input cmd_e cmd, input logic [WIDTH_W-1:0] iv,
                           input logic [SEL_W-1:0] sel);
    if (in_gap_pct > 0 && $urandom_range(0, 99) < in_gap_pct) begin
      item_bus.valid = 1'b0;
      repeat ($urandom_range(1, 9)) @(negedge clk_i);
    end
    item_bus.valid          = 1'b1;
    item_bus.command        = cmd;
    item_bus.interval_us    = iv;
    item_bus.channel_select = sel;
    do @(posedge clk_i); while (!item_bus.ready);
    sb.predict_item(cmd, iv, sel);
    items_sent++;
    // valid stays up; the caller either drives the next beat now or idles
    @(negedge clk_i);
  endtask

  task automatic drain_results();
    item_bus.valid = 1'b0;
    while (sb.due_beats.size() != 0) @(negedge clk_i);
  endtask

  // Register writes only with the pipe empty.
  task automatic write_sync_gap(input logic [WIDTH_W-1:0] v);
    drain_results();
    repeat (4) @(negedge clk_i);
    cfg_bus.valid = 1'b1;
    cfg_bus.data  = v;
    do @(posedge clk_i); while (!cfg_bus.ready);
    sb.set_sync_gap(v);
    @(negedge clk_i);
    cfg_bus.valid = 1'b0;
    gap_settings++;
  endtask

  function automatic logic [WIDTH_W-1:0] any_bits();
    return $urandom_range(0, 16'hFFFF);
  endfunction

  // Pulse width for one slot, never above the sync gap.
  function automatic logic [WIDTH_W-1:0] stick_width(stick_mode_e mode, int ch);
    int unsigned w;
    int unsigned gap;
    gap = sb.sync_gap;
    if ($urandom_range(0, 11) == 0) begin
      case ($urandom_range(0, 2))
        0:       w = 0;
        1:       w = gap;
        default: w = $urandom_range(0, gap);
      endcase
      return w;
    end
    if (mode == STICKS_ANY) begin
      w = $urandom_range(900, 2100);
    end else begin
      case (ch)
        2:       w = $urandom_range(900, 1049);
        3:       w = (mode == STICKS_ARM) ? $urandom_range(1901, 2100)
                                          : $urandom_range(1000, 1599);
        4:       w = $urandom_range(1801, 2100);
        5:       w = $urandom_range(900, 1199);
        default: w = $urandom_range(1000, 2000);
      endcase
    end
    if (w > gap) w = $urandom_range(0, gap);
    return w;
  endfunction

  // Frame start; with the gap at full scale no interval can sync.
  task automatic send_sync();
    int unsigned gap;
    logic [WIDTH_W-1:0] iv;
    gap = sb.sync_gap;
    if (gap == 16'hFFFF) begin
      iv = any_bits();
    end else begin
      case ($urandom_range(0, 3))
        0:       iv = gap + 1;
        1:       iv = 16'hFFFF;
        default: iv = $urandom_range(gap + 1, 16'hFFFF);
      endcase
    end
    send_item(CMD_EDGE, iv, $urandom_range(0, 7));
  endtask

  task automatic send_frame(input stick_mode_e mode);
    int n;
    n = ($urandom_range(0, 9) < 7) ? N_CH : $urandom_range(0, 11);
    send_sync();
    for (int ch = 0; ch < n; ch++)
      send_item(CMD_EDGE, stick_width(mode, ch), $urandom_range(0, 7));
  endtask

  task automatic start_arming();
    arm_age    = 0;
    release_at = $urandom_range(2, 48);
    send_item(CMD_ARM, any_bits(), $urandom_range(0, 7));
  endtask

  // Mostly well-formed traffic: frames shaped to walk the arming sequence,
  // tick runs, arm and cal starts; the rest is noise and pressure pauses.
  task automatic run_random(input int count);
    int          target;
    int          r;
    stick_mode_e mode;
    cmd_e        c;
    target = items_sent + count;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 40) begin
        if ($urandom_range(0, 9) == 0) mode = STICKS_ANY;
        else mode = (arm_age < release_at) ? STICKS_ARM : STICKS_REL;
        send_frame(mode);
      end else if (r < 78) begin
        repeat ($urandom_range(1, 16)) begin
          send_item(CMD_TICK, any_bits(), $urandom_range(0, 7));
          arm_age++;
        end
      end else if (r < 83) begin
        start_arming();
      end else if (r < 89) begin
        send_item(CMD_CAL, any_bits(), $urandom_range(0, 7));
      end else if (r < 98) begin
        c = cmd_e'($urandom_range(0, 3));
        if (c == CMD_ARM) begin
          arm_age    = 0;
          release_at = $urandom_range(2, 48);
        end
        send_item(c, any_bits(), $urandom_range(0, 7));
      end else if (in_gap_pct > 0) begin
        drain_results();
      end
    end
  endtask

  // Short directed pass at the reset gap of 5000: pulses before any sync,
  // interval equal to the gap, the threshold boundaries of the arm pattern,
  // a pulse past the last slot, and restarts of both sequencers.
  task automatic run_directed();
    send_item(CMD_TICK, 16'hFFFF, 3'd0);
    send_item(CMD_EDGE, 16'd1500, 3'd7);
    send_item(CMD_EDGE, 16'd5000, 3'd0);
    send_item(CMD_EDGE, 16'd5001, 3'd1);
    send_item(CMD_EDGE, 16'd0,    3'd0);
    send_item(CMD_EDGE, 16'd5000, 3'd1);
    send_item(CMD_EDGE, 16'd1049, 3'd2);
    send_item(CMD_EDGE, 16'd1901, 3'd3);
    send_item(CMD_EDGE, 16'd1801, 3'd4);
    send_item(CMD_EDGE, 16'd1199, 3'd5);
    send_item(CMD_EDGE, 16'd1500, 3'd6);
    send_item(CMD_EDGE, 16'd2000, 3'd7);
    send_item(CMD_EDGE, 16'd1234, 3'd7);
    send_item(CMD_EDGE, 16'hFFFF, 3'd3);
    send_item(CMD_ARM,  16'h0000, 3'd3);
    send_item(CMD_TICK, 16'hAAAA, 3'd2);
    send_item(CMD_ARM,  16'h5555, 3'd4);
    send_item(CMD_CAL,  16'hFFFF, 3'd5);
    send_item(CMD_TICK, 16'h0000, 3'd0);
    send_item(CMD_CAL,  16'h1234, 3'd1);
    send_item(CMD_EDGE, 16'd0,    3'd0);
    send_item(CMD_TICK, 16'h8001, 3'd1);
    send_item(CMD_TICK, 16'h7FFE, 3'd3);
  endtask

  initial begin
    rst_ni                  = 1'b0;
    cfg_bus.valid           = 1'b0;
    cfg_bus.data            = '0;
    item_bus.valid          = 1'b0;
    item_bus.command        = CMD_EDGE;
    item_bus.interval_us    = '0;
    item_bus.channel_select = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    in_gap_pct    = 20;
    out_stall_pct = 20;
    run_directed();

    // Wide gap: large widths get stored and the calibration sums grow big.
    write_sync_gap(16'd40000);
    in_gap_pct    = 25;
    out_stall_pct = 25;
    run_random(200);

    // Full-scale gap: nothing can sync; a stretch with no idling at all.
    write_sync_gap(16'hFFFF);
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_random(110);

    // Zero gap: only zero-width pulses store, heavy idling on both sides.
    write_sync_gap(16'd0);
    in_gap_pct    = 40;
    out_stall_pct = 40;
    run_random(100);

    write_sync_gap(any_bits());
    in_gap_pct    = 15;
    out_stall_pct = 30;
    run_random(150);

    write_sync_gap(16'd5000);
    in_gap_pct    = 20;
    out_stall_pct = 20;
    run_random(600);

    // Closing stretch at full rate.
    in_gap_pct    = 0;
    out_stall_pct = 0;
    run_random(180);

    item_bus.valid = 1'b0;
    while (sb.due_beats.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (sb.due_beats.size() != 0) begin
      sb.errors += sb.due_beats.size();
      $display("%0d result beats never arrived", sb.due_beats.size());
    end

    $display("%0d item beats sent, %0d result beats checked, %0d sync-gap settings",
             items_sent, sb.checked, gap_settings);
    $display("frame syncs %0d, arming completions %0d, calibrations %0d, errors %0d",
             sb.syncs, sb.arms, sb.cals, sb.errors);
    if (sb.errors == 0) begin
      $display("ppm_receiver_with_arming_core: match");
    end else begin
      $display("ppm_receiver_with_arming_core: mismatch");
    end
    $finish;
  end

endmodule

### ppm_receiver_with_arming_core.f
design/ppmra_pkg.sv
design/ppmra_if.sv
design/ppmra_chan_store.sv
design/ppm_receiver_with_arming_core.sv
bench/tb_ppm_receiver_with_arming_core.sv
